FILE: rtl/ddid_pkg.sv
// Shared constants, stage types and the month table for the date difference block.
package ddid_pkg;

    localparam int DAY_W    = 5;
    localparam int MON_W    = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 22;
    localparam int SERIAL_W = 23;
    localparam int LEAPS_W  = 13;

    localparam logic [MON_W-1:0] MON_FIRST = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB   = 4'd2;
    localparam logic [MON_W-1:0] MON_LAST  = 4'd12;

    localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 23'd365;
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 22'd4194303;

    // Floor division of a small value by 25 is a multiply by 5243 and a shift by 17.
    // The excess of 3 in 25 * 5243 stays below one step for inputs under 43690.
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MON_W-1:0]    mon;
        logic [YEAR_W-1:0]   yr;
        logic [12:0]         q4;    // ceil(y / 4)
        logic [12:0]         a100;  // floor((y + 99) / 4)
        logic [10:0]         a400;  // floor((y + 399) / 16)
        logic [SERIAL_W-1:0] y365;
    } s1_t;

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MON_W-1:0]    mon;
        logic [YEAR_W-1:0]   yr;
        logic [12:0]         q4;
        logic [25:0]         p100;
        logic [23:0]         p400;
        logic [SERIAL_W-1:0] y365;
    } s2_t;

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MON_W-1:0]    mon;
        logic [LEAPS_W-1:0]  leaps;
        logic                leap;
        logic [SERIAL_W-1:0] y365;
    } s3_t;

    // Days in the year before the first of the month, for a common year.
    function automatic logic [8:0] days_before(input logic [MON_W-1:0] mon);
        logic [8:0] d;
        case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/date_difference_in_days.sv
// Top level of the date difference block: a five-stage pipeline from two dates to a day count.
//
// A query word (start date, end date, include_end) is taken at a rising edge with start
// high and busy low. busy is held low: the pipeline takes a new word on every clock.
// Both dates run side by side through five register stages: month clamp and year offsets,
// the reciprocal multiplies for the century terms, the leap count and leap-year test, the
// serial day number, and finally the difference with include_end and saturation.
// The result appears on day_count with done high for exactly one cycle; both are registered
// in the last stage, and results leave in the order the words came in.
// Sustained rate is one word per clock; the depth of five is set by the multiply stage and
// the wide serial adds on each side of it.
// The receiver cannot hold a result off, so the pipeline never stalls and needs no skid
// storage. Reset clears the valid bits of all stages; words in flight are dropped and done
// stays low until a new word has passed through.
module date_difference_in_days (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ddid_pkg::DAY_W-1:0]    start_day,
    input  logic [ddid_pkg::MON_W-1:0]    start_month,
    input  logic [ddid_pkg::YEAR_W-1:0]   start_year,
    input  logic [ddid_pkg::DAY_W-1:0]    end_day,
    input  logic [ddid_pkg::MON_W-1:0]    end_month,
    input  logic [ddid_pkg::YEAR_W-1:0]   end_year,
    input  logic                          include_end,
    output logic                          done,
    output logic [ddid_pkg::COUNT_W-1:0]  day_count
);
    import ddid_pkg::*;

    logic [DAY_W-1:0]    in_day  [2];
    logic [MON_W-1:0]    in_mon  [2];
    logic [YEAR_W-1:0]   in_yr   [2];

    s1_t s1_next [2];
    s1_t s1_reg  [2];
    s2_t s2_next [2];
    s2_t s2_reg  [2];
    s3_t s3_next [2];
    s3_t s3_reg  [2];
    logic [SERIAL_W-1:0] s4_next [2];
    logic [SERIAL_W-1:0] s4_reg  [2];

    logic [3:0] inc_reg;
    logic [3:0] valid_reg;

    logic [SERIAL_W:0]    diff;
    logic [COUNT_W-1:0]   count_next;
    logic [COUNT_W-1:0]   count_reg;
    logic                 done_reg;

    assign busy = 1'b0;

    assign in_day[0] = start_day;
    assign in_mon[0] = start_month;
    assign in_yr[0]  = start_year;
    assign in_day[1] = end_day;
    assign in_mon[1] = end_month;
    assign in_yr[1]  = end_year;

    always_comb
    begin
        for (int g = 0; g < 2; g++)
        begin
            logic [14:0] y3;
            logic [14:0] y99;
            logic [14:0] y399;
            logic [8:0]  c100;
            logic [6:0]  c400;
            logic        div4;
            logic        div100;
            logic        div400;

            // Stage 1: clamp the month, form the offsets for the three ceilings and multiply the year by 365.
            s1_next[g].day = in_day[g];
            if (in_mon[g] < MON_FIRST)
            begin
                s1_next[g].mon = MON_FIRST;
            end
            else if (in_mon[g] > MON_LAST)
            begin
                s1_next[g].mon = MON_LAST;
            end
            else
            begin
                s1_next[g].mon = in_mon[g];
            end
            s1_next[g].yr   = in_yr[g];
            y3              = 15'(in_yr[g]) + 15'd3;
            y99             = 15'(in_yr[g]) + 15'd99;
            y399            = 15'(in_yr[g]) + 15'd399;
            s1_next[g].q4   = y3[14:2];
            s1_next[g].a100 = y99[14:2];
            s1_next[g].a400 = y399[14:4];
            s1_next[g].y365 = SERIAL_W'(in_yr[g]) * DAYS_PER_YEAR;

            // Stage 2: divide by 25 through the reciprocal.
            s2_next[g].day  = s1_reg[g].day;
            s2_next[g].mon  = s1_reg[g].mon;
            s2_next[g].yr   = s1_reg[g].yr;
            s2_next[g].q4   = s1_reg[g].q4;
            s2_next[g].y365 = s1_reg[g].y365;
            s2_next[g].p100 = 26'(s1_reg[g].a100) * 26'(RECIP_25);
            s2_next[g].p400 = 24'(s1_reg[g].a400) * 24'(RECIP_25);

            // Stage 3: leap years before this one, and whether this one is a leap year.
            // A ceiling that times its divisor gives back the year means the year divides.
            c100   = s2_reg[g].p100[RECIP_SHIFT +: 9];
            c400   = s2_reg[g].p400[RECIP_SHIFT +: 7];
            div4   = (s2_reg[g].yr[1:0] == 2'b00);
            div100 = ((16'(c100) * 16'd100) == 16'(s2_reg[g].yr));
            div400 = ((16'(c400) * 16'd400) == 16'(s2_reg[g].yr));
            s3_next[g].day   = s2_reg[g].day;
            s3_next[g].mon   = s2_reg[g].mon;
            s3_next[g].y365  = s2_reg[g].y365;
            s3_next[g].leaps = s2_reg[g].q4 - LEAPS_W'(c100) + LEAPS_W'(c400);
            s3_next[g].leap  = (div4 && !div100) || div400;

            // Stage 4: serial day number from the start of year zero.
            s4_next[g] = s3_reg[g].y365
                       + SERIAL_W'(s3_reg[g].leaps)
                       + SERIAL_W'(days_before(s3_reg[g].mon))
                       + SERIAL_W'((s3_reg[g].mon > MON_FEB) && s3_reg[g].leap)
                       + SERIAL_W'(s3_reg[g].day);
        end
    end

    // Stage 5: the difference, clipped at zero, plus include_end, saturated to the field.
    always_comb
    begin
        if (s4_reg[1] > s4_reg[0])
        begin
            diff = {1'b0, s4_reg[1] - s4_reg[0]} + (SERIAL_W+1)'(inc_reg[3]);
        end
        else
        begin
            diff = (SERIAL_W+1)'(inc_reg[3]);
        end
        if (diff > (SERIAL_W+1)'(COUNT_MAX))
        begin
            count_next = COUNT_MAX;
        end
        else
        begin
            count_next = diff[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], start && !busy};
            done_reg  <= valid_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < 2; g++)
        begin
            s1_reg[g] <= s1_next[g];
            s2_reg[g] <= s2_next[g];
            s3_reg[g] <= s3_next[g];
            s4_reg[g] <= s4_next[g];
        end
        inc_reg   <= {inc_reg[2:0], include_end};
        count_reg <= count_next;
    end

    assign done      = done_reg;
    assign day_count = count_reg;

endmodule

FILE: bench/date_difference_in_days_tb.sv
// Self-checking testbench for the date difference block: directed and random date pairs.
`timescale 1ns / 100ps

module date_difference_in_days_tb;

    import ddid_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_WORDS  = 119;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PERCENT  = 34;
    localparam int REPORT_CAP    = 10;

    typedef struct {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  mon;
        logic [YEAR_W-1:0] yr;
    } date_t;

    typedef struct {
        date_t from_date;
        date_t to_date;
        logic  inc;
        bit    drain_first;
    } query_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [DAY_W-1:0]    start_day = '0;
    logic [MON_W-1:0]    start_month = '0;
    logic [YEAR_W-1:0]   start_year = '0;
    logic [DAY_W-1:0]    end_day = '0;
    logic [MON_W-1:0]    end_month = '0;
    logic [YEAR_W-1:0]   end_year = '0;
    logic                include_end = 1'b0;
    logic                done;
    logic [COUNT_W-1:0]  day_count;

    query_t             pending_queries[$];
    logic [COUNT_W-1:0] expected_counts[$];

    logic word_taken = 1'b0;
    int   total_words = 0;
    int   words_presented = 0;
    int   words_accepted = 0;
    int   counts_checked = 0;
    int   saturated_counts = 0;
    int   zero_counts = 0;
    int   error_count = 0;
    int   cycle_count = 0;

    date_difference_in_days dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .start_day   (start_day),
        .start_month (start_month),
        .start_year  (start_year),
        .end_day     (end_day),
        .end_month   (end_month),
        .end_year    (end_year),
        .include_end (include_end),
        .done        (done),
        .day_count   (day_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        int unsigned len;
        case (m)
            2:       len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default: len = 31;
        endcase
        return len;
    endfunction

    // Day number counted from the first day of year 0; out-of-range months are clamped,
    // and the day of month is a plain offset, so day 0 lands on the previous day.
    function automatic int unsigned date_serial(input date_t dt);
        int unsigned m;
        int unsigned y;
        int unsigned serial;
        m = dt.mon;
        y = dt.yr;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        serial = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (int unsigned k = 1; k < m; k++)
            serial += month_length(k, 1);
        if (m > 2 && leap_year(y))
            serial += 1;
        return serial + dt.day;
    endfunction

    function automatic logic [COUNT_W-1:0] days_between(input date_t a, input date_t b,
                                                          input logic inc);
        int unsigned sa;
        int unsigned sb;
        int unsigned span;
        sa = date_serial(a);
        sb = date_serial(b);
        span = (sb > sa) ? sb - sa : 0;
        span += inc;
        if (span > COUNT_MAX)
            span = COUNT_MAX;
        return span[COUNT_W-1:0];
    endfunction

    function automatic date_t make_date(input int unsigned d, input int unsigned m,
                                        input int unsigned y);
        date_t dt;
        dt.day = d[DAY_W-1:0];
        dt.mon = m[MON_W-1:0];
        dt.yr  = y[YEAR_W-1:0];
        return dt;
    endfunction

    function automatic date_t random_valid_date(input int unsigned lo_yr, input int unsigned hi_yr);
        int unsigned y;
        int unsigned m;
        y = $urandom_range(hi_yr, lo_yr);
        m = $urandom_range(12, 1);
        return make_date($urandom_range(month_length(m, y), 1), m, y);
    endfunction

    function automatic date_t random_raw_date();
        return make_date($urandom_range(31), $urandom_range(15), $urandom_range(16383));
    endfunction

    task automatic add_query(input date_t a, input date_t b, input logic inc, input bit drain);
        query_t q;
        q.from_date   = a;
        q.to_date     = b;
        q.inc         = inc;
        q.drain_first = drain;
        pending_queries.push_back(q);
        total_words++;
    endtask

    // Driver: a new word goes out only once the previous one was taken.
    always @(negedge clk)
    begin
        query_t q;
        bit     calm;
        bit     hold;
        if (rst_n && (!start || word_taken))
        begin
            calm = (words_presented >= 60) && (words_presented < 100);
            hold = (pending_queries.size() == 0)
                || (pending_queries[0].drain_first && expected_counts.size() != 0)
                || (!calm && $urandom_range(99) < IDLE_PERCENT);
            if (hold)
            begin
                start <= 1'b0;
            end
            else
            begin
                q = pending_queries.pop_front();
                start_day   <= q.from_date.day;
                start_month <= q.from_date.mon;
                start_year  <= q.from_date.yr;
                end_day     <= q.to_date.day;
                end_month   <= q.to_date.mon;
                end_year    <= q.to_date.yr;
                include_end <= q.inc;
                start       <= 1'b1;
                words_presented++;
            end
        end
    end

    // Monitor: checks each result against the oldest expected count, then records
    // the word taken at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        logic [COUNT_W-1:0] want;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (expected_counts.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                        $display("ERROR: result %0d with no word outstanding", day_count);
                end
                else
                begin
                    want = expected_counts.pop_front();
                    counts_checked++;
                    if (day_count !== want)
                    begin
                        error_count++;
                        if (error_count <= REPORT_CAP)
                            $display("ERROR: day_count expected %0d, got %0d", want, day_count);
                    end
                end
            end
            word_taken <= start && (busy === 1'b0);
            if (start && (busy === 1'b0))
            begin
                want = days_between(make_date(start_day, start_month, start_year),
                                    make_date(end_day, end_month, end_year), include_end);
                expected_counts.push_back(want);
                words_accepted++;
                if (want == COUNT_MAX)
                    saturated_counts++;
                if (want == 0)
                    zero_counts++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_counts.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        date_t a;
        date_t b;
        int    pick;

        // Directed words: field extremes, leap rules, clamped months, odd days, saturation.
        add_query(make_date(1, 1, 1), make_date(31, 12, 9999), 1'b0, 1'b0);
        add_query(make_date(1, 1, 1), make_date(31, 12, 9999), 1'b1, 1'b0);
        add_query(make_date(14, 7, 2010), make_date(14, 7, 2010), 1'b0, 1'b0);
        add_query(make_date(14, 7, 2010), make_date(14, 7, 2010), 1'b1, 1'b0);
        add_query(make_date(2, 3, 2011), make_date(1, 3, 2011), 1'b1, 1'b0);
        add_query(make_date(28, 2, 2024), make_date(1, 3, 2024), 1'b0, 1'b0);
        add_query(make_date(28, 2, 1900), make_date(1, 3, 1900), 1'b0, 1'b0);
        add_query(make_date(28, 2, 2000), make_date(1, 3, 2000), 1'b1, 1'b0);
        add_query(make_date(31, 12, 1999), make_date(1, 1, 2000), 1'b0, 1'b0);
        add_query(make_date(15, 0, 2020), make_date(15, 1, 2020), 1'b1, 1'b0);
        add_query(make_date(1, 12, 2020), make_date(31, 15, 2020), 1'b0, 1'b0);
        add_query(make_date(5, 13, 1987), make_date(5, 14, 1988), 1'b0, 1'b0);
        add_query(make_date(0, 3, 2021), make_date(1, 3, 2021), 1'b0, 1'b0);
        add_query(make_date(31, 4, 2021), make_date(1, 5, 2021), 1'b1, 1'b0);
        add_query(make_date(31, 2, 2023), make_date(3, 3, 2023), 1'b0, 1'b0);
        add_query(make_date(1, 1, 0), make_date(1, 1, 1), 1'b0, 1'b0);
        add_query(make_date(1, 1, 10000), make_date(1, 1, 16383), 1'b1, 1'b0);
        add_query(make_date(1, 1, 0), make_date(1, 1, 12000), 1'b0, 1'b0);
        add_query(make_date(0, 0, 0), make_date(31, 15, 16383), 1'b1, 1'b0);
        add_query(make_date(31, 15, 16383), make_date(0, 0, 0), 1'b1, 1'b0);
        add_query(make_date(29, 2, 2400), make_date(29, 2, 2404), 1'b0, 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                a = random_valid_date(1, 9999);
                b = random_valid_date(1, 9999);
            end
            else if (pick < 60)
            begin
                a = random_valid_date(1, 9998);
                b = random_valid_date(a.yr, a.yr + 1);
            end
            else if (pick < 68)
            begin
                a = random_valid_date(1, 9999);
                b = a;
            end
            else if (pick < 85)
            begin
                a = random_raw_date();
                b = random_raw_date();
            end
            else if (pick < 95)
            begin
                a = random_valid_date(1, 9999);
                b = random_valid_date(a.yr, 9999);
                a.mon = $urandom_range(1) ? MON_W'($urandom_range(15, 13)) : '0;
                b.day = $urandom_range(1) ? '0 : DAY_W'($urandom_range(31, 29));
            end
            else
            begin
                a = random_valid_date(0, 4000);
                b = random_valid_date(12000, 16383);
            end
            // The sender waits for the pipeline to drain before the random part and again
            // in the middle of it.
            add_query(a, b, 1'($urandom_range(1)), (n == 0) || (n == RANDOM_WORDS / 2));
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (words_accepted == total_words);
        wait (expected_counts.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d date pairs: %0d counts checked, %0d zero, %0d saturated.",
                 words_accepted, counts_checked, zero_counts, saturated_counts);
        $display("Clamped months, out-of-month days and years past 9999 were included.");
        if (error_count == 0 && expected_counts.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d errors", error_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ddid_pkg.sv
rtl/date_difference_in_days.sv
bench/date_difference_in_days_tb.sv
